// ===== design/fraction_reduce_assert.svh =====
// ----------------------------------------------------------------------------
// fraction_reduce assertion macros
// Concurrent checks for the fraction reducer, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCE_ASSERT_SVH
`define FRACTION_REDUCE_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every rising clock edge outside reset.
`define FR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("fraction_reduce: check failed");

// Condition never holds outside reset.
`define FR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("fraction_reduce: forbidden condition");

`else

`define FR_ASSERT(lbl, clk, rst_n, prop)
`define FR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== design/fr_pkg.sv =====
// ----------------------------------------------------------------------------
// fr_pkg
// Shared result status codes for the fraction reducer.
// ----------------------------------------------------------------------------
package fr_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	localparam int unsigned STATUS_W = 2;

endpackage

// ===== design/fr_div.sv =====
// ----------------------------------------------------------------------------
// fr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "fraction_reduce_assert.svh"

module fr_div #(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;

	logic [WIDTH:0]   partial;
	logic [WIDTH+1:0] trial;
	logic             geq;

	assign partial = {rem_q, quo_q[WIDTH-1]};
	assign trial   = {1'b0, partial} - {2'b00, dvs_q};
	assign geq     = ~trial[WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: load operands on start, shift one quotient bit in per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= geq ? trial[WIDTH-1:0] : partial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], geq};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`FR_NEVER(a_start_while_busy, clk, arst_n, start && busy_q)
	`FR_ASSERT(a_busy_nonzero_divisor, clk, arst_n, busy_q |-> (dvs_q != '0))
	`FR_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> ($past(busy_q) && !busy_q))

endmodule

// ===== design/fraction_reduce.sv =====
// Flow: a zero numerator or denominator goes from accept straight to S_FINISH;
// otherwise the binary GCD steps, whose number depends on the data, run first,
// then two divisions one after the other on the shared divider.
// Throughput: one item at a time; a new item is taken once the previous one
// is parked in the output register. Reset clears all control state.
// ----------------------------------------------------------------------------
// fraction_reduce
// Reduces a signed fraction to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
`include "fraction_reduce_assert.svh"

module fraction_reduce #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic signed [DATA_WIDTH-1:0] numerator,
	input  logic signed [DATA_WIDTH-1:0] denominator,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic signed [DATA_WIDTH-1:0] reduced_numerator,
	output logic        [DATA_WIDTH-2:0] reduced_denominator,
	output logic [fr_pkg::STATUS_W-1:0]  status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_COMMON,
		S_REDUCE,
		S_DIV_NUM,
		S_DIV_DEN,
		S_FINISH
	} state_t;

	state_t state_q;

	logic [DATA_WIDTH-1:0] mn_q;
	logic [DATA_WIDTH-1:0] md_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [DATA_WIDTH-1:0] rn_q;
	logic                  rneg_q;

	logic [DATA_WIDTH-1:0] res_num_q;
	logic [DATA_WIDTH-2:0] res_den_q;
	fr_pkg::status_t       res_status_q;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_num_q;
	logic [DATA_WIDTH-2:0] out_den_q;
	fr_pkg::status_t       out_status_q;

	logic [DATA_WIDTH-1:0] mag_n;
	logic [DATA_WIDTH-1:0] mag_d;
	logic [DATA_WIDTH:0]   diff_ab;
	logic [DATA_WIDTH-1:0] diff_ba;
	logic                  accept;
	logic                  out_take;
	logic                  out_free;

	logic                  div_start;
	logic [DATA_WIDTH-1:0] div_dividend;
	logic                  div_done;
	logic [DATA_WIDTH-1:0] div_quotient;
	logic                  ovf;

	assign mag_n = numerator[DATA_WIDTH-1]
		? ({DATA_WIDTH{1'b0}} - $unsigned(numerator)) : $unsigned(numerator);
	assign mag_d = denominator[DATA_WIDTH-1]
		? ({DATA_WIDTH{1'b0}} - $unsigned(denominator)) : $unsigned(denominator);

	assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba = b_q - a_q;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_take   = out_valid_q && result_ready;
	assign out_free   = !out_valid_q || result_ready;

	// the odd part of the GCD sits in a_q; mn_q and md_q already carry the
	// common power of two removed
	assign div_start = ((state_q == S_REDUCE) && (b_q == '0))
		|| ((state_q == S_DIV_NUM) && div_done);
	assign div_dividend = (state_q == S_REDUCE) ? mn_q : md_q;

	assign ovf = div_quotient[DATA_WIDTH-1] || (!rneg_q && rn_q[DATA_WIDTH-1]);

	fr_div #(
		.WIDTH(DATA_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (a_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			res_status_q <= fr_pkg::ST_OK;
			out_status_q <= fr_pkg::ST_OK;
		end else begin
			// a finishing item reloads the register in the same cycle
			if (out_take && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rneg_q <= numerator[DATA_WIDTH-1] ^ denominator[DATA_WIDTH-1];
						priority if (mag_d == '0) begin
							res_num_q    <= '0;
							res_den_q    <= '0;
							res_status_q <= fr_pkg::ST_ZERO_DEN;
							state_q      <= S_FINISH;
						end else if (mag_n == '0) begin
							res_num_q    <= '0;
							res_den_q    <= {{(DATA_WIDTH-2){1'b0}}, 1'b1};
							res_status_q <= fr_pkg::ST_OK;
							state_q      <= S_FINISH;
						end else begin
							mn_q    <= mag_n;
							md_q    <= mag_d;
							a_q     <= mag_n;
							b_q     <= mag_d;
							state_q <= S_COMMON;
						end
					end
				end
				S_COMMON: begin
					// strip the shared factors of two from both operands
					priority if (!a_q[0] && !b_q[0]) begin
						a_q  <= a_q >> 1;
						b_q  <= b_q >> 1;
						mn_q <= mn_q >> 1;
						md_q <= md_q >> 1;
					end else if (!a_q[0]) begin
						a_q     <= b_q;
						b_q     <= a_q;
						state_q <= S_REDUCE;
					end else begin
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					priority if (b_q == '0) begin
						state_q <= S_DIV_NUM;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (diff_ab[DATA_WIDTH]) begin
						b_q <= diff_ba;
					end else begin
						a_q <= b_q;
						b_q <= diff_ab[DATA_WIDTH-1:0];
					end
				end
				S_DIV_NUM: begin
					if (div_done) begin
						rn_q    <= div_quotient;
						state_q <= S_DIV_DEN;
					end
				end
				S_DIV_DEN: begin
					if (div_done) begin
						if (ovf) begin
							res_num_q    <= '0;
							res_den_q    <= '0;
							res_status_q <= fr_pkg::ST_OVERFLOW;
						end else begin
							res_num_q    <= rneg_q ? ({DATA_WIDTH{1'b0}} - rn_q) : rn_q;
							res_den_q    <= div_quotient[DATA_WIDTH-2:0];
							res_status_q <= fr_pkg::ST_OK;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_num_q    <= res_num_q;
						out_den_q    <= res_den_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid        = out_valid_q;
	assign reduced_numerator   = $signed(out_num_q);
	assign reduced_denominator = out_den_q;
	assign status              = out_status_q;

	`FR_ASSERT(a_accept_leaves_idle, clk, arst_n, accept |=> (state_q != S_IDLE))
	`FR_ASSERT(a_reduce_a_odd, clk, arst_n, (state_q == S_REDUCE) |-> a_q[0])
	`FR_ASSERT(a_ok_den_nonzero, clk, arst_n,
		(out_valid_q && (out_status_q == fr_pkg::ST_OK)) |-> (out_den_q != '0))
	`FR_ASSERT(a_err_fields_zero, clk, arst_n,
		(out_valid_q && (out_status_q != fr_pkg::ST_OK)) |-> ((out_num_q == '0) && (out_den_q == '0)))
	`FR_NEVER(a_done_outside_div, clk, arst_n,
		div_done && (state_q != S_DIV_NUM) && (state_q != S_DIV_DEN))

endmodule

// ===== bench/tb_fraction_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_reduce
// Self-checking bench for the fraction reducer: directed corner fractions,
// then random beats with shared factors, extreme values and random idling
// on both channels, checked against a behavioral lowest-terms predictor.
// ----------------------------------------------------------------------------
module tb_fraction_reduce;

	localparam int DW           = 32;
	localparam int RANDOM_ITEMS = 725;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PRINT_CAP    = 40;

	localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};

	typedef struct {
		logic [DW-1:0]   num;
		logic [DW-2:0]   den;
		fr_pkg::status_t st;
	} reduced_t;

	class lowest_terms_board;
		reduced_t reduced_q[$];
		int       errors;

		function new();
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function reduced_t reduce_fraction(logic signed [DW-1:0] n, logic signed [DW-1:0] d);
			logic [DW-1:0]   mn, md, low;
			bit              nneg, dneg, rneg;
			longint unsigned a, b, r, rn, rd, half;
			reduced_t        res;
			res.num = '0;
			res.den = '0;
			res.st  = fr_pkg::ST_OK;
			half = longint'(1) << (DW - 1);
			nneg = n[DW-1];
			dneg = d[DW-1];
			mn = nneg ? -n : n;
			md = dneg ? -d : d;
			if (md == 0) begin
				res.st = fr_pkg::ST_ZERO_DEN;
				return res;
			end
			if (mn == 0) begin
				res.den = (DW-1)'(1);
				return res;
			end
			a = 64'(mn);
			b = 64'(md);
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			rn = mn / a;
			rd = md / a;
			rneg = nneg ^ dneg;
			// flag a value that cannot be represented once the sign is applied
			if (rd >= half || (!rneg && rn >= half)) begin
				res.st = fr_pkg::ST_OVERFLOW;
				return res;
			end
			low = rn[DW-1:0];
			res.num = rneg ? -low : low;
			res.den = rd[DW-2:0];
			return res;
		endfunction

		function void note_fraction(logic [DW-1:0] n, logic [DW-1:0] d);
			reduced_q.push_back(reduce_fraction(n, d));
		endfunction

		task check_reduced(logic [DW-1:0] rn, logic [DW-2:0] rd,
			logic [fr_pkg::STATUS_W-1:0] st);
			reduced_t want;
			if (reduced_q.size() == 0) begin
				report($sformatf("result %0d/%0d status %0d with nothing pending",
					$signed(rn), rd, st));
				return;
			end
			want = reduced_q.pop_front();
			if (st !== want.st)
				report($sformatf("status %0d, want %s", st, want.st.name()));
			if (rn !== want.num)
				report($sformatf("reduced_numerator %0d, want %0d",
					$signed(rn), $signed(want.num)));
			if (rd !== want.den)
				report($sformatf("reduced_denominator %0d, want %0d", rd, want.den));
		endtask
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               item_valid;
	logic                               item_ready;
	logic signed [DW-1:0]               numerator;
	logic signed [DW-1:0]               denominator;
	logic                               result_valid;
	logic                               result_ready;
	logic signed [DW-1:0]               reduced_numerator;
	logic        [DW-2:0]               reduced_denominator;
	logic        [fr_pkg::STATUS_W-1:0] status;

	lowest_terms_board board = new();
	bit                quiet;
	int                idle_cycles;

	fraction_reduce #(.DATA_WIDTH(DW)) dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.item_valid          (item_valid),
		.item_ready          (item_ready),
		.numerator           (numerator),
		.denominator         (denominator),
		.result_valid        (result_valid),
		.result_ready        (result_ready),
		.reduced_numerator   (reduced_numerator),
		.reduced_denominator (reduced_denominator),
		.status              (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.check_reduced(reduced_numerator, reduced_denominator, status);
	end

	// end the run when neither channel moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall bursts unless quiet
	initial begin
		result_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	task automatic send_fraction(input logic [DW-1:0] n, input logic [DW-1:0] d);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 19);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		numerator   <= n;
		denominator <= d;
		do @(posedge clk); while (!item_ready);
		board.note_fraction(n, d);
	endtask

	function automatic logic [DW-1:0] rand_operand(int unsigned kind);
		logic [DW-1:0] v;
		case (kind)
			0: v = $urandom;
			1: v = $urandom_range(0, 200) - 100;
			2: begin
				case ($urandom_range(0, 7))
					0: v = '0;
					1: v = 1;
					2: v = '1;
					3: v = MIN_VAL;
					4: v = MAX_VAL;
					5: v = MIN_VAL + 1;
					6: v = 1 << $urandom_range(0, DW - 1);
					default: v = -(1 << $urandom_range(0, DW - 2));
				endcase
			end
			default: begin
				v = $urandom_range(1, 1000) << $urandom_range(0, 21);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	initial begin
		logic [DW-1:0] n, d, g;
		arst_n      <= 1'b0;
		item_valid  <= 1'b0;
		numerator   <= '0;
		denominator <= '0;
		quiet       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero numerator and zero denominator
		send_fraction(0, 0);
		send_fraction(0, 7);
		send_fraction(0, MIN_VAL);
		send_fraction(5, 0);
		send_fraction(MIN_VAL, 0);
		// sign placement
		send_fraction(12, 18);
		send_fraction(-12, 18);
		send_fraction(12, -18);
		send_fraction(-12, -18);
		send_fraction(-1, 1);
		send_fraction(1, -1);
		// overflow on sign flip and on a denominator of the most negative value
		send_fraction(MIN_VAL, -1);
		send_fraction(MIN_VAL, -3);
		send_fraction(1, MIN_VAL);
		send_fraction(3, MIN_VAL);
		send_fraction(MAX_VAL, MIN_VAL);
		// most negative values that still reduce into range
		send_fraction(MIN_VAL, 1);
		send_fraction(MIN_VAL, MIN_VAL);
		send_fraction(2, MIN_VAL);
		send_fraction(MIN_VAL, 2);
		send_fraction(MIN_VAL, -2);
		send_fraction(MAX_VAL, MAX_VAL);
		send_fraction(MAX_VAL, -1);
		send_fraction(MIN_VAL + 1, -1);
		// consecutive Fibonacci numbers: longest Euclid chain
		send_fraction(1836311903, 1134903170);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i % 200 < 30) || (i >= RANDOM_ITEMS - 100);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					g = $urandom_range(1, 1 << $urandom_range(1, 16));
					n = $urandom_range(0, 3000) * g;
					d = $urandom_range(1, 3000) * g;
					if ($urandom_range(0, 1))
						n = -n;
					if ($urandom_range(0, 1))
						d = -d;
				end
				4, 5: begin
					n = $urandom;
					d = $urandom;
				end
				default: begin
					n = rand_operand($urandom_range(0, 3));
					d = rand_operand($urandom_range(0, 3));
				end
			endcase
			send_fraction(n, d);
		end
		quiet = 1'b1;
		item_valid <= 1'b0;

		while (board.reduced_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.reduced_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
